// ===== design/shd_pkg.sv =====
package shd_pkg;

    // window geometry and sync pattern
    localparam int WIN_LEN = 16;
    localparam int FILL_W  = 4;
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_LEN - 1);
    localparam logic [15:0] SYNC_WORD = 16'hAA55;

    // configuration port
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_TYPE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNKS = CFG_IDX_W'(3);

    // register reset values
    localparam logic [7:0]  RST_IMAGE_TYPE = 8'd1;
    localparam logic [15:0] RST_MAX_WIDTH  = 16'd640;
    localparam logic [15:0] RST_MAX_HEIGHT = 16'd480;
    localparam logic [15:0] RST_MAX_CHUNKS = 16'd2048;

    // result kinds
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    typedef logic [WIN_LEN-1:0][7:0] t_win;

    typedef struct packed {
        logic [7:0]  image_type_code;
        logic [15:0] max_width;
        logic [15:0] max_height;
        logic [15:0] max_chunks;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  pkt_type;
        logic [7:0]  pkt_event;
        logic [15:0] img_width;
        logic [15:0] img_height;
        logic [15:0] chunk_id;
        logic [15:0] chunk_total;
        logic [15:0] payload_bytes;
    } t_hdr;

    typedef struct packed {
        logic        kind;
        t_hdr        hdr;
        logic [7:0]  data_byte;
        logic        last;
    } t_res;

endpackage

// ===== design/shd_ifs.sv =====
interface shd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

interface shd_res_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_event;
    logic [15:0] img_width;
    logic [15:0] img_height;
    logic [15:0] chunk_id;
    logic [15:0] chunk_total;
    logic [15:0] payload_bytes;
    logic [7:0]  data_byte;
    logic        last;

    modport source (
        output valid, output kind, output pkt_type, output pkt_event,
        output img_width, output img_height, output chunk_id,
        output chunk_total, output payload_bytes, output data_byte,
        output last, input ready
    );
    modport sink (
        input valid, input kind, input pkt_type, input pkt_event,
        input img_width, input img_height, input chunk_id,
        input chunk_total, input payload_bytes, input data_byte,
        input last, output ready
    );
endinterface

interface shd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [shd_pkg::CFG_IDX_W-1:0]     index;
    logic [shd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/shd_cfg_regs.sv =====
module shd_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    shd_cfg_if.sink       i_cfg,
    output shd_pkg::t_cfg o_cfg
);

    shd_pkg::t_cfg r_cfg;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register file, indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_type_code <= shd_pkg::RST_IMAGE_TYPE;
            r_cfg.max_width       <= shd_pkg::RST_MAX_WIDTH;
            r_cfg.max_height      <= shd_pkg::RST_MAX_HEIGHT;
            r_cfg.max_chunks      <= shd_pkg::RST_MAX_CHUNKS;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                shd_pkg::REG_IMAGE_TYPE: r_cfg.image_type_code <= i_cfg.data[7:0];
                shd_pkg::REG_MAX_WIDTH:  r_cfg.max_width       <= i_cfg.data;
                shd_pkg::REG_MAX_HEIGHT: r_cfg.max_height      <= i_cfg.data;
                shd_pkg::REG_MAX_CHUNKS: r_cfg.max_chunks      <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== design/shd_hdr_check.sv =====
module shd_hdr_check (
    input  shd_pkg::t_win i_win,
    input  shd_pkg::t_cfg i_cfg,
    output shd_pkg::t_hdr o_hdr,
    output logic          o_ok
);

    logic w_sync_ok;
    logic w_is_image;
    logic w_dims_ok;
    logic w_total_ok;

    // field extraction, little endian
    assign o_hdr.pkt_type      = i_win[2];
    assign o_hdr.pkt_event     = i_win[3];
    assign o_hdr.img_width     = {i_win[5],  i_win[4]};
    assign o_hdr.img_height    = {i_win[7],  i_win[6]};
    assign o_hdr.chunk_id      = {i_win[9],  i_win[8]};
    assign o_hdr.chunk_total   = {i_win[11], i_win[10]};
    assign o_hdr.payload_bytes = {i_win[13], i_win[12]};

    // sync word and image sanity rule
    assign w_sync_ok  = ({i_win[1], i_win[0]} == shd_pkg::SYNC_WORD);
    assign w_is_image = (i_win[2] == i_cfg.image_type_code);
    assign w_dims_ok  = (o_hdr.img_width != 16'd0) && (o_hdr.img_height != 16'd0)
                     && (o_hdr.img_width <= i_cfg.max_width)
                     && (o_hdr.img_height <= i_cfg.max_height);
    assign w_total_ok = (o_hdr.chunk_total != 16'd0)
                     && (o_hdr.chunk_total <= i_cfg.max_chunks);

    assign o_ok = w_sync_ok && (!w_is_image || (w_dims_ok && w_total_ok));

endmodule

// ===== design/sync_header_packet_deframer.sv =====
// an accepted byte is held in the input stage register, and its result in the result register
// throughput: one byte per cycle while the result side takes results
// the window shift, header compare and payload count are done in the same cycle for each byte
// reset (synchronous, active low) clears the window fill, payload state and
// pending requests, and loads the configuration registers with their defaults
module sync_header_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    shd_byte_if.sink   i_in,
    shd_cfg_if.sink    i_cfg,
    shd_res_if.source  o_res
);

    shd_pkg::t_cfg w_cfg;
    shd_pkg::t_hdr w_hdr;
    logic          w_hdr_ok;

    // input stage
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // deframer state
    shd_pkg::t_win              r_win;
    shd_pkg::t_win              n_win;
    shd_pkg::t_win              w_shift_win;
    logic [shd_pkg::FILL_W-1:0] r_fill;
    logic [shd_pkg::FILL_W-1:0] n_fill;
    logic                       r_in_payload;
    logic                       n_in_payload;
    logic [15:0]                r_bytes_left;
    logic [15:0]                n_bytes_left;

    // result stage
    logic          r_out_valid;
    shd_pkg::t_res r_res;
    shd_pkg::t_res n_res;
    logic          w_res_fire;

    logic w_proc;
    logic w_in_acc;

    shd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // window with the new byte shifted in, oldest byte at index 0
    assign w_shift_win = {r_in_byte, r_win[shd_pkg::WIN_LEN-1:1]};

    // the shifted window is what gets tested
    shd_hdr_check u_check (
        .i_win (w_shift_win),
        .i_cfg (w_cfg),
        .o_hdr (w_hdr),
        .o_ok  (w_hdr_ok)
    );

    // handshake
    assign w_proc     = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = !r_in_valid || w_proc;

    // next state and result
    always_comb begin
        n_win        = r_win;
        n_fill       = r_fill;
        n_in_payload = r_in_payload;
        n_bytes_left = r_bytes_left;
        n_res        = '0;
        w_res_fire   = 1'b0;
        if (w_proc) begin
            if (r_in_payload) begin
                w_res_fire      = 1'b1;
                n_res.kind      = shd_pkg::KIND_PAYLOAD;
                n_res.data_byte = r_in_byte;
                n_res.last      = (r_bytes_left <= 16'd1);
                if (r_bytes_left != 16'd0) begin
                    n_bytes_left = r_bytes_left - 16'd1;
                end
                if (r_bytes_left <= 16'd1) begin
                    n_in_payload = 1'b0;
                    n_fill       = '0;
                end
            end else begin
                n_win = w_shift_win;
                if (r_fill == shd_pkg::FILL_FULL) begin
                    if (w_hdr_ok) begin
                        w_res_fire = 1'b1;
                        n_res.kind = shd_pkg::KIND_HEADER;
                        n_res.hdr  = w_hdr;
                        n_res.last = (w_hdr.payload_bytes == 16'd0);
                        n_fill     = '0;
                        if (w_hdr.payload_bytes != 16'd0) begin
                            n_in_payload = 1'b1;
                            n_bytes_left = w_hdr.payload_bytes;
                        end
                    end
                end else begin
                    n_fill = r_fill + shd_pkg::FILL_W'(1);
                end
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_fill       <= '0;
            r_in_payload <= 1'b0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end
            r_fill       <= n_fill;
            r_in_payload <= n_in_payload;
            r_bytes_left <= n_bytes_left;
            if (w_res_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_in.byte_in;
        end
        r_win <= n_win;
        if (w_res_fire) begin
            r_res <= n_res;
        end
    end

    // result port
    assign o_res.valid         = r_out_valid;
    assign o_res.kind          = r_res.kind;
    assign o_res.pkt_type      = r_res.hdr.pkt_type;
    assign o_res.pkt_event     = r_res.hdr.pkt_event;
    assign o_res.img_width     = r_res.hdr.img_width;
    assign o_res.img_height    = r_res.hdr.img_height;
    assign o_res.chunk_id      = r_res.hdr.chunk_id;
    assign o_res.chunk_total   = r_res.hdr.chunk_total;
    assign o_res.payload_bytes = r_res.hdr.payload_bytes;
    assign o_res.data_byte     = r_res.data_byte;
    assign o_res.last          = r_res.last;

endmodule

// ===== test/sync_header_packet_deframer_tb.sv =====
`timescale 1ns / 100ps

module sync_header_packet_deframer_tb;
    import shd_pkg::*;

    localparam int RANDOM_ITEMS = 1100;
    localparam int RANDOM_PHASES = 6;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;
    localparam int MAX_REPORTS = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    shd_byte_if byte_bus ();
    shd_cfg_if  cfg_bus ();
    shd_res_if  res_bus ();

    sync_header_packet_deframer i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (byte_bus),
        .i_cfg   (cfg_bus),
        .o_res   (res_bus)
    );

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct = 0;

    logic res_ready = 1'b0;
    logic res_hold = 1'b0;
    event hold_ev;

    int error_count = 0;
    int bytes_sent = 0;
    int quiet_cycles = 0;

    // deframer shadow state
    logic [7:0]  win_q [WIN_LEN];
    int          win_fill = 0;
    bit          payload_active = 1'b0;
    logic [15:0] payload_left = 16'd0;
    t_cfg        cfg_q = '{RST_IMAGE_TYPE, RST_MAX_WIDTH, RST_MAX_HEIGHT, RST_MAX_CHUNKS};

    t_res frames_due [$];

    // clock
    initial begin
        forever #6 clk = ~clk;
    end

    // little-endian word from the window
    function automatic logic [15:0] win_word(int pos);
        return {win_q[pos + 1], win_q[pos]};
    endfunction

    // sync word plus image sanity rule
    function automatic bit frame_accepted();
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] tot;
        w = win_word(4);
        h = win_word(6);
        tot = win_word(10);
        if (win_word(0) != SYNC_WORD)
            return 1'b0;
        if (win_q[2] != cfg_q.image_type_code)
            return 1'b1;
        return w != 16'd0 && w <= cfg_q.max_width && h != 16'd0 && h <= cfg_q.max_height
            && tot != 16'd0 && tot <= cfg_q.max_chunks;
    endfunction

    // advance the shadow deframer by one byte, returns 1 when a result is due
    function automatic bit deframe_step(input logic [7:0] b, output t_res r);
        bit produced;
        produced = 1'b0;
        r = '0;
        if (payload_active) begin
            r.kind = KIND_PAYLOAD;
            r.data_byte = b;
            r.last = (payload_left <= 16'd1);
            if (payload_left != 16'd0)
                payload_left = payload_left - 16'd1;
            if (payload_left == 16'd0) begin
                payload_active = 1'b0;
                win_fill = 0;
            end
            produced = 1'b1;
        end else begin
            win_q[win_fill] = b;
            win_fill++;
            if (win_fill == WIN_LEN) begin
                if (frame_accepted()) begin
                    r.kind = KIND_HEADER;
                    r.hdr.pkt_type = win_q[2];
                    r.hdr.pkt_event = win_q[3];
                    r.hdr.img_width = win_word(4);
                    r.hdr.img_height = win_word(6);
                    r.hdr.chunk_id = win_word(8);
                    r.hdr.chunk_total = win_word(10);
                    r.hdr.payload_bytes = win_word(12);
                    r.last = (r.hdr.payload_bytes == 16'd0);
                    win_fill = 0;
                    if (r.hdr.payload_bytes != 16'd0) begin
                        payload_active = 1'b1;
                        payload_left = r.hdr.payload_bytes;
                    end
                    produced = 1'b1;
                end else begin
                    // drop the oldest byte and try the next start position later
                    for (int i = 0; i < WIN_LEN - 1; i++)
                        win_q[i] = win_q[i + 1];
                    win_fill = WIN_LEN - 1;
                end
            end
        end
        return produced;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_frame(t_res want, t_res got);
        check_field("kind", 16'(want.kind), 16'(got.kind));
        check_field("pkt_type", 16'(want.hdr.pkt_type), 16'(got.hdr.pkt_type));
        check_field("pkt_event", 16'(want.hdr.pkt_event), 16'(got.hdr.pkt_event));
        check_field("img_width", want.hdr.img_width, got.hdr.img_width);
        check_field("img_height", want.hdr.img_height, got.hdr.img_height);
        check_field("chunk_id", want.hdr.chunk_id, got.hdr.chunk_id);
        check_field("chunk_total", want.hdr.chunk_total, got.hdr.chunk_total);
        check_field("payload_bytes", want.hdr.payload_bytes, got.hdr.payload_bytes);
        check_field("data_byte", 16'(want.data_byte), 16'(got.data_byte));
        check_field("last", 16'(want.last), 16'(got.last));
    endtask

    // track every request on all three channels
    always @(posedge clk) begin
        t_res got;
        t_res want;
        if (rst_n) begin
            if (res_bus.valid && res_bus.ready) begin
                got.kind = res_bus.kind;
                got.hdr.pkt_type = res_bus.pkt_type;
                got.hdr.pkt_event = res_bus.pkt_event;
                got.hdr.img_width = res_bus.img_width;
                got.hdr.img_height = res_bus.img_height;
                got.hdr.chunk_id = res_bus.chunk_id;
                got.hdr.chunk_total = res_bus.chunk_total;
                got.hdr.payload_bytes = res_bus.payload_bytes;
                got.data_byte = res_bus.data_byte;
                got.last = res_bus.last;
                if (frames_due.size() == 0) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: result with none expected, expected nothing, actual %0h",
                            $time, got);
                end else begin
                    want = frames_due.pop_front();
                    compare_frame(want, got);
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                case (cfg_bus.index)
                    REG_IMAGE_TYPE: cfg_q.image_type_code = cfg_bus.data[7:0];
                    REG_MAX_WIDTH:  cfg_q.max_width = cfg_bus.data;
                    REG_MAX_HEIGHT: cfg_q.max_height = cfg_bus.data;
                    REG_MAX_CHUNKS: cfg_q.max_chunks = cfg_bus.data;
                    default: ;
                endcase
            end
            if (byte_bus.valid && byte_bus.ready) begin
                if (deframe_step(byte_bus.byte_in, want))
                    frames_due = {frames_due, want};
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(posedge clk) begin
        if (!rst_n || (byte_bus.valid && byte_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side ready with random stalls
    assign res_bus.ready = res_ready;

    always @(posedge clk) begin
        res_ready <= !res_hold && ($urandom_range(99) >= stall_pct);
    end

    // long receiver hold-off
    always begin
        @(hold_ev);
        res_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_hold <= 1'b0;
    end

    task automatic send_byte(logic [7:0] b);
        byte_bus.valid <= 1'b1;
        byte_bus.byte_in <= b;
        do @(posedge clk); while (!byte_bus.ready);
        bytes_sent++;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            byte_bus.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // upper byte of the type write is junk that must be masked off
    task automatic write_cfg(t_cfg c);
        write_reg(REG_IMAGE_TYPE, {8'($urandom), c.image_type_code});
        write_reg(REG_MAX_WIDTH, c.max_width);
        write_reg(REG_MAX_HEIGHT, c.max_height);
        write_reg(REG_MAX_CHUNKS, c.max_chunks);
    endtask

    // wait until every expected result is out, then cover the pipeline latency
    task automatic drain_results();
        byte_bus.valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic t_hdr mk_hdr(logic [7:0] typ, logic [7:0] evt, logic [15:0] w,
                                    logic [15:0] h, logic [15:0] id, logic [15:0] tot,
                                    logic [15:0] plen);
        t_hdr r;
        r.pkt_type = typ;
        r.pkt_event = evt;
        r.img_width = w;
        r.img_height = h;
        r.chunk_id = id;
        r.chunk_total = tot;
        r.payload_bytes = plen;
        return r;
    endfunction

    // wire layout of a header, reserved bytes random
    function automatic t_win make_header(t_hdr h);
        t_win hb;
        hb[0] = SYNC_WORD[7:0];
        hb[1] = SYNC_WORD[15:8];
        hb[2] = h.pkt_type;
        hb[3] = h.pkt_event;
        hb[4] = h.img_width[7:0];
        hb[5] = h.img_width[15:8];
        hb[6] = h.img_height[7:0];
        hb[7] = h.img_height[15:8];
        hb[8] = h.chunk_id[7:0];
        hb[9] = h.chunk_id[15:8];
        hb[10] = h.chunk_total[7:0];
        hb[11] = h.chunk_total[15:8];
        hb[12] = h.payload_bytes[7:0];
        hb[13] = h.payload_bytes[15:8];
        hb[14] = 8'($urandom);
        hb[15] = 8'($urandom);
        return hb;
    endfunction

    task automatic send_header_bytes(t_win hb, int count);
        int k;
        for (k = 0; k < count; k++)
            send_byte(hb[k]);
    endtask

    task automatic send_packet(t_hdr h);
        int n;
        send_header_bytes(make_header(h), WIN_LEN);
        for (n = 0; n < int'(h.payload_bytes); n++)
            send_byte(8'($urandom));
    endtask

    // limit field value clustered around the accept boundaries
    function automatic logic [15:0] pick_bounded(logic [15:0] lim);
        case ($urandom_range(11))
            0: return 16'd0;
            1: return 16'd1;
            2: return lim;
            3: return lim + 16'd1;
            4: return 16'($urandom_range(65535));
            default: return (lim == 16'd0) ? 16'd0 : 16'($urandom_range(lim, 1));
        endcase
    endfunction

    function automatic t_hdr random_header();
        t_hdr h;
        int pick;
        h.pkt_type = ($urandom_range(9) < 7) ? cfg_q.image_type_code : 8'($urandom);
        h.pkt_event = 8'($urandom);
        h.img_width = pick_bounded(cfg_q.max_width);
        h.img_height = pick_bounded(cfg_q.max_height);
        h.chunk_id = 16'($urandom);
        h.chunk_total = pick_bounded(cfg_q.max_chunks);
        pick = $urandom_range(99);
        if (pick < 10)
            h.payload_bytes = 16'd0;
        else if (pick < 70)
            h.payload_bytes = 16'($urandom_range(6, 1));
        else if (pick < 95)
            h.payload_bytes = 16'($urandom_range(24, 7));
        else
            h.payload_bytes = 16'($urandom_range(120, 25));
        return h;
    endfunction

    // mostly whole packets, some cut short, some noise, some with a bad sync
    task automatic send_random_frame();
        int pick;
        int n;
        int k;
        t_win hb;
        pick = $urandom_range(99);
        if (pick < 72) begin
            send_packet(random_header());
        end else if (pick < 82) begin
            send_header_bytes(make_header(random_header()), $urandom_range(15, 2));
        end else if (pick < 92) begin
            n = $urandom_range(8, 1);
            for (k = 0; k < n; k++) begin
                case ($urandom_range(3))
                    0: send_byte(SYNC_WORD[7:0]);
                    1: send_byte(SYNC_WORD[15:8]);
                    default: send_byte(8'($urandom));
                endcase
            end
        end else begin
            hb = make_header(random_header());
            k = $urandom_range(1);
            hb[k] = hb[k] ^ 8'($urandom_range(255, 1));
            send_header_bytes(hb, WIN_LEN);
        end
    endtask

    function automatic t_cfg random_cfg(int mode);
        t_cfg c;
        case (mode)
            0: c = '{8'($urandom_range(3)), 16'($urandom_range(1000, 1)),
                     16'($urandom_range(1000, 1)), 16'($urandom_range(1000, 1))};
            1: c = '{8'($urandom), 16'($urandom_range(4, 1)),
                     16'($urandom_range(4, 1)), 16'($urandom_range(4, 1))};
            2: c = '{8'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF};
            3: c = '{RST_IMAGE_TYPE, RST_MAX_WIDTH, RST_MAX_HEIGHT, RST_MAX_CHUNKS};
            4: begin
                c = '{8'($urandom_range(3)), 16'($urandom_range(64, 1)),
                      16'($urandom_range(64, 1)), 16'($urandom_range(64, 1))};
                case ($urandom_range(2))
                    0: c.max_width = 16'd0;
                    1: c.max_height = 16'd0;
                    default: c.max_chunks = 16'd0;
                endcase
            end
            default: c = '{8'($urandom), 16'($urandom_range(65535, 1)),
                           16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1))};
        endcase
        return c;
    endfunction

    // reset limits: boundaries, rejects, empty and short payloads
    task automatic test_default_limits();
        send_byte(8'h00);
        send_byte(SYNC_WORD[7:0]);
        send_byte(SYNC_WORD[7:0]);
        send_packet(mk_hdr(8'd1, 8'h00, 16'd640, 16'd480, 16'd0, 16'd2048, 16'd3));
        send_packet(mk_hdr(8'd1, 8'h11, 16'd641, 16'd480, 16'd1, 16'd10, 16'd2));
        send_packet(mk_hdr(8'd1, 8'h22, 16'd0, 16'd1, 16'd2, 16'd1, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h33, 16'd1, 16'd481, 16'd3, 16'd1, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h44, 16'd1, 16'd0, 16'd4, 16'd1, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h55, 16'd1, 16'd1, 16'd5, 16'd0, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h66, 16'd1, 16'd1, 16'd6, 16'd2049, 16'd0));
        send_packet(mk_hdr(8'h07, 8'hFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h5A, 16'd1, 16'd1, 16'hFFFF, 16'd1, 16'd1));
        // empty payload, the next header follows right away
        send_packet(mk_hdr(8'd1, 8'h00, 16'd320, 16'd240, 16'd5, 16'd10, 16'd0));
        send_packet(mk_hdr(8'd1, 8'h01, 16'd320, 16'd240, 16'd6, 16'd10, 16'd4));
    endtask

    // all-ones, minimum and zero limits, masked and ignored writes
    task automatic test_register_extremes();
        drain_results();
        write_reg(REG_IMAGE_TYPE, 16'hFFFF);
        write_reg(REG_MAX_WIDTH, 16'hFFFF);
        write_reg(REG_MAX_HEIGHT, 16'hFFFF);
        write_reg(REG_MAX_CHUNKS, 16'hFFFF);
        write_reg(REG_MAX_CHUNKS + 8'd1, 16'h0000);
        write_reg(8'hFF, 16'h0000);
        send_packet(mk_hdr(8'hFF, 8'hA5, 16'hFFFF, 16'hFFFF, 16'h1234, 16'hFFFF, 16'd2));
        send_packet(mk_hdr(8'h01, 8'h5A, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));

        drain_results();
        write_cfg('{8'h00, 16'd1, 16'd1, 16'd1});
        send_packet(mk_hdr(8'h00, 8'h01, 16'd1, 16'd1, 16'd7, 16'd1, 16'd1));
        send_packet(mk_hdr(8'h00, 8'h02, 16'd2, 16'd1, 16'd7, 16'd1, 16'd0));
        send_packet(mk_hdr(8'h00, 8'h03, 16'd1, 16'd2, 16'd7, 16'd1, 16'd0));
        send_packet(mk_hdr(8'h00, 8'h04, 16'd1, 16'd1, 16'd7, 16'd2, 16'd0));

        // zero limits lock out the image type only
        drain_results();
        write_cfg('{8'h00, 16'd0, 16'd0, 16'd0});
        send_packet(mk_hdr(8'h00, 8'h05, 16'd1, 16'd1, 16'd8, 16'd1, 16'd0));
        send_packet(mk_hdr(8'h00, 8'h06, 16'd0, 16'd0, 16'd8, 16'd0, 16'd0));
        send_packet(mk_hdr(8'h03, 8'h07, 16'd1, 16'd1, 16'd8, 16'd1, 16'd1));
    endtask

    // long payload with both length bytes in use
    task automatic test_long_payload();
        send_packet(mk_hdr(8'h80, 8'h3C, 16'h8001, 16'h7FFE, 16'hAAAA, 16'h5555, 16'd260));
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_backpressure();
        int k;
        drain_results();
        send_idle_pct = 0;
        stall_pct = 0;
        -> hold_ev;
        for (k = 0; k < 5; k++)
            send_packet(mk_hdr(8'h80 + 8'(k), 8'(k), 16'd9, 16'd9, 16'(k), 16'd5, 16'd12));
    endtask

    // random traffic under several register settings and idle patterns
    task automatic test_random_traffic();
        int ph;
        int stop_at;
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain_results();
            case (ph % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 76;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 76;
                end
                default: begin
                    send_idle_pct = 38;
                    stall_pct = 38;
                end
            endcase
            write_cfg(random_cfg(ph));
            stop_at = bytes_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (bytes_sent < stop_at)
                send_random_frame();
        end
    endtask

    // sequence of tests
    initial begin
        byte_bus.valid <= 1'b0;
        byte_bus.byte_in <= 8'h00;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= '0;
        cfg_bus.data <= '0;
        rst_n <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_default_limits();
        test_register_extremes();
        test_long_payload();
        test_backpressure();
        test_random_traffic();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
